>>> rtl/core/bbs_pkg.sv
package bbs_pkg;

  localparam int COUNT_W = 21;
  localparam int RATIO_W = 24;
  localparam int SCORE_W = 7;
  localparam int TGT_W   = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [RATIO_W-1:0] RATIO_MAX  = {RATIO_W{1'b1}};
  localparam logic [SCORE_W-1:0] SCORE_FULL = 7'd100;

  // configuration register indexes
  localparam logic CFG_VERT_TARGET = 1'b0;
  localparam logic CFG_HORZ_TARGET = 1'b1;

  localparam logic [TGT_W-1:0] VERT_TARGET_RST = 24'd8192;
  localparam logic [TGT_W-1:0] HORZ_TARGET_RST = 24'd385024;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AREA,
    ST_PERIM,
    ST_PREP,
    ST_RDIV,
    ST_SQRT,
    ST_RATIO,
    ST_RATDIV,
    ST_QSET,
    ST_QDIV,
    ST_SCALE,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic full;
    logic avail;
  } queue_status_t;

endpackage

>>> rtl/core/bbs_front.sv
module bbs_front #(
  parameter int C = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [C-1:0]                px,
  input  logic [C-1:0]                py,
  input  logic                        first_point,
  input  logic                        last_point,
  output logic                        push,
  output logic [C-1:0]                snap_left,
  output logic [C-1:0]                snap_top,
  output logic [C:0]                  snap_width,
  output logic [C:0]                  snap_height,
  output logic [bbs_pkg::COUNT_W-1:0] snap_count
);
  import bbs_pkg::*;

  logic [C-1:0]       min_col, max_col, min_row, max_row;
  logic [C-1:0]       min_col_next, max_col_next, min_row_next, max_row_next;
  logic [COUNT_W-1:0] point_count, point_count_next;

  always_comb begin
    if (first_point) begin
      min_col_next     = px;
      max_col_next     = px;
      min_row_next     = py;
      max_row_next     = py;
      point_count_next = COUNT_W'(1);
    end else begin
      min_col_next     = (px < min_col) ? px : min_col;
      max_col_next     = (px > max_col) ? px : max_col;
      min_row_next     = (py < min_row) ? py : min_row;
      max_row_next     = (py > max_row) ? py : max_row;
      point_count_next = (point_count == COUNT_MAX) ? point_count : point_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_col     <= '0;
      max_col     <= '0;
      min_row     <= '0;
      max_row     <= '0;
      point_count <= '0;
    end else if (accept) begin
      min_col     <= min_col_next;
      max_col     <= max_col_next;
      min_row     <= min_row_next;
      max_row     <= max_row_next;
      point_count <= point_count_next;
    end
  end

  // snapshot includes the closing point itself
  assign push        = accept & last_point;
  assign snap_left   = min_col_next;
  assign snap_top    = min_row_next;
  assign snap_width  = {1'b0, max_col_next} - {1'b0, min_col_next} + 1'b1;
  assign snap_height = {1'b0, max_row_next} - {1'b0, min_row_next} + 1'b1;
  assign snap_count  = point_count_next;

endmodule

>>> rtl/core/bbs_queue.sv
module bbs_queue #(
  parameter int W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [W-1:0]          din,
  input  logic                  pop,
  output logic [W-1:0]          dout,
  output bbs_pkg::queue_status_t status
);
  import bbs_pkg::*;

  logic [W-1:0] mem [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   fill;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  assign dout         = mem[rd_ptr];
  assign status.full  = fill[1];
  assign status.avail = (fill != 2'd0);

endmodule

>>> rtl/core/bbs_back.sv
module bbs_back #(
  parameter int C = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bbs_pkg::queue_status_t      q_status,
  input  logic [C-1:0]                q_left,
  input  logic [C-1:0]                q_top,
  input  logic [C:0]                  q_width,
  input  logic [C:0]                  q_height,
  input  logic [bbs_pkg::COUNT_W-1:0] q_count,
  output logic                        q_pop,
  input  logic [bbs_pkg::TGT_W-1:0]   vert_target,
  input  logic [bbs_pkg::TGT_W-1:0]   horz_target,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [C-1:0]                box_left,
  output logic [C-1:0]                box_top,
  output logic [C:0]                  box_width,
  output logic [C:0]                  box_height,
  output logic [bbs_pkg::COUNT_W-1:0] pixel_total,
  output logic [bbs_pkg::SCORE_W-1:0] rect_score,
  output logic [bbs_pkg::SCORE_W-1:0] aspect_score,
  output logic                        is_vertical
);
  import bbs_pkg::*;

  localparam int W1      = C + 1;
  localparam int AW      = 2 * C + 2;
  localparam int PW      = C + 3;
  localparam int SQW     = 2 * PW;
  localparam int NW      = ((29 > AW) ? 29 : AW) + 1;
  localparam int DISC_W  = (SQW > 26) ? SQW : 26;
  localparam int RAD_W   = DISC_W + 16;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int LW      = ((PW + 8 > ROOT_W) ? PW + 8 : ROOT_W) + 1;
  localparam int DW0     = (LW + 16 > NW) ? LW + 16 : NW;
  localparam int DW      = (DW0 > 41) ? DW0 : 41;
  localparam int DSW     = DW + RATIO_W;
  localparam int STEP_W  = $clog2(((ROOT_W > RATIO_W) ? ROOT_W : RATIO_W) + 1);
  localparam int RECT_BITS = SCORE_W;
  localparam int Q_BITS  = 17;

  back_state_t state, state_next;

  logic [C-1:0]       left_r, top_r;
  logic [W1-1:0]      w_r, h_r;
  logic [COUNT_W-1:0] cnt_r;
  logic               vert;
  logic [AW-1:0]      area;
  logic [NW-1:0]      cnt200, nsum;
  logic [PW-1:0]      p;
  logic [SQW-1:0]     sq;
  logic               rsat, ratsat, qsat;
  logic [SCORE_W-1:0] rect;
  logic [23:0]        prod;

  // shared restoring divider
  logic [DW-1:0]      rem;
  logic [DSW-1:0]     dsh;
  logic [RATIO_W-1:0] quo;
  logic [STEP_W-1:0]  step;
  logic               div_ge;

  // square root recurrence
  logic [RAD_W-1:0]   sv, sres, sbit, st;
  logic               sq_ge;

  logic [DISC_W-1:0]  disc_sq, disc_sub, disc;
  logic [ROOT_W-1:0]  root;
  logic [LW-1:0]      p_sh, lng, sht, rnum, rden;
  logic [RATIO_W-1:0] ratio;
  logic [TGT_W-1:0]   tgt;
  logic [Q_BITS-1:0]  qv, mval;
  logic               out_free;

  assign div_ge   = {{(DSW-DW){1'b0}}, rem} >= dsh;
  assign st       = sres + sbit;
  assign sq_ge    = sv >= st;
  assign disc_sq  = DISC_W'(sq);
  assign disc_sub = DISC_W'({cnt_r, 4'b0000});
  assign disc     = (disc_sq > disc_sub) ? disc_sq - disc_sub : '0;
  assign root     = sres[ROOT_W-1:0];
  assign p_sh     = LW'({p, 8'h00});
  assign lng      = p_sh + LW'(root);
  assign sht      = p_sh - LW'(root);
  assign rnum     = vert ? sht : lng;
  assign rden     = vert ? lng : sht;
  assign ratio    = ratsat ? RATIO_MAX : quo;
  assign tgt      = ((vert ? vert_target : horz_target) == '0) ? TGT_W'(1)
                  : (vert ? vert_target : horz_target);
  assign qv       = quo[Q_BITS-1:0];
  assign mval     = qsat ? '0
                  : (qv <= Q_BITS'(65536)) ? qv : Q_BITS'(131072) - qv;
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == ST_IDLE) && q_status.avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (q_status.avail) state_next = ST_AREA;
      ST_AREA:   state_next = ST_PERIM;
      ST_PERIM:  state_next = ST_PREP;
      ST_PREP:   state_next = ST_RDIV;
      ST_RDIV:   if (step == '0) state_next = ST_SQRT;
      ST_SQRT:   if (step == '0) state_next = ST_RATIO;
      ST_RATIO:  state_next = ST_RATDIV;
      ST_RATDIV: if (step == '0) state_next = ST_QSET;
      ST_QSET:   state_next = ST_QDIV;
      ST_QDIV:   if (step == '0) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        left_r <= q_left;
        top_r  <= q_top;
        w_r    <= q_width;
        h_r    <= q_height;
        cnt_r  <= q_count;
      end
      ST_AREA: begin
        area   <= w_r * h_r;
        cnt200 <= NW'(cnt_r) * NW'(200);
        p      <= PW'({w_r, 1'b0}) + PW'({h_r, 1'b0});
        vert   <= h_r > w_r;
      end
      ST_PERIM: begin
        sq   <= p * p;
        nsum <= cnt200 + NW'(area);
      end
      ST_PREP: begin
        rsat <= (NW + 8)'(nsum) >= (NW + 8)'(area) * (NW + 8)'(202);
        rem  <= DW'(nsum);
        dsh  <= DSW'({area, 1'b0, 6'b000000});
        quo  <= '0;
        step <= STEP_W'(RECT_BITS - 1);
        sv   <= {disc, 16'h0000};
        sres <= '0;
        sbit <= RAD_W'(1) << (RAD_W - 2);
      end
      ST_RDIV, ST_RATDIV, ST_QDIV: begin
        if (div_ge) begin
          rem <= rem - dsh[DW-1:0];
        end
        quo  <= {quo[RATIO_W-2:0], div_ge};
        dsh  <= dsh >> 1;
        if (step == '0) begin
          step <= STEP_W'(ROOT_W - 1);
        end else begin
          step <= step - 1'b1;
        end
      end
      ST_SQRT: begin
        rect <= rsat ? SCORE_FULL : quo[SCORE_W-1:0];
        if (sq_ge) begin
          sv   <= sv - st;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
        step <= step - 1'b1;
      end
      ST_RATIO: begin
        ratsat <= (LW + 8)'(rnum) >= (LW + 8)'({rden, 8'h00});
        rem    <= DW'({rnum, 16'h0000});
        dsh    <= DSW'({rden, 23'h0});
        quo    <= '0;
        step   <= STEP_W'(RATIO_W - 1);
      end
      ST_QSET: begin
        qsat <= (TGT_W + 1)'(ratio) >= {tgt, 1'b0};
        rem  <= DW'({ratio, 16'h0000});
        dsh  <= DSW'({tgt, 16'h0000});
        quo  <= '0;
        step <= STEP_W'(Q_BITS - 1);
      end
      ST_SCALE: begin
        prod <= 24'(mval) * 24'd100;
      end
      default: begin
      end
    endcase
  end

  // result register, parts the scorer from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      box_left     <= left_r;
      box_top      <= top_r;
      box_width    <= w_r;
      box_height   <= h_r;
      pixel_total  <= cnt_r;
      rect_score   <= rect;
      aspect_score <= SCORE_W'((25'(prod) + 25'd32768) >> 16);
      is_vertical  <= vert;
    end
  end

endmodule

>>> rtl/core/blob_box_and_shape_scorer_core.sv
// Channel | Handshake              | Payload
// --------+------------------------+------------------------------------------
// in      | in_valid / in_stall    | px, py, first_point, last_point
// out     | out_valid / out_stall  | box_left, box_top, box_width, box_height,
//         |                        | pixel_total, rect_score, aspect_score,
//         |                        | is_vertical
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Points go in one per cycle unless stalled; the box tracker updates on transfer.
// Each particle in the back end runs a rect divide, a square root, a ratio
// divide and a target divide, with setup, handoff and output states around them.
// The divider is shared by the three divides, and the back end takes a new
// particle only once the last has left ST_DONE; a stalled result holds it there.
// A two-entry queue holds closed particles; in_stall rises only while it is full.
// Reset (rst, synchronous) clears the box, count, queue and targets to defaults.
module blob_box_and_shape_scorer_core #(
  parameter int COORD_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  // pixel stream
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [COORD_BITS-1:0]       px,
  input  logic [COORD_BITS-1:0]       py,
  input  logic                        first_point,
  input  logic                        last_point,
  // particle results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [COORD_BITS-1:0]       box_left,
  output logic [COORD_BITS-1:0]       box_top,
  output logic [COORD_BITS:0]         box_width,
  output logic [COORD_BITS:0]         box_height,
  output logic [bbs_pkg::COUNT_W-1:0] pixel_total,
  output logic [bbs_pkg::SCORE_W-1:0] rect_score,
  output logic [bbs_pkg::SCORE_W-1:0] aspect_score,
  output logic                        is_vertical,
  // register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [bbs_pkg::TGT_W-1:0]   cfg_data
);
  import bbs_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int SNAP_W = 4 * C + 2 + COUNT_W;

  logic [TGT_W-1:0]   vert_target, horz_target;
  logic               in_xfer, push;
  logic [C-1:0]       s_left, s_top, d_left, d_top;
  logic [C:0]         s_width, s_height, d_width, d_height;
  logic [COUNT_W-1:0] s_count, d_count;
  logic [SNAP_W-1:0]  q_dout;
  logic               q_pop;
  queue_status_t      q_status;

  // targets, always ready; user writes only with no particle in flight, unchecked
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vert_target <= VERT_TARGET_RST;
      horz_target <= HORZ_TARGET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VERT_TARGET: vert_target <= cfg_data;
        CFG_HORZ_TARGET: horz_target <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_status.full;
  assign in_xfer  = in_valid && !in_stall;

  // front: per-point box and count tracking
  bbs_front #(.C(C)) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_xfer),
    .px          (px),
    .py          (py),
    .first_point (first_point),
    .last_point  (last_point),
    .push        (push),
    .snap_left   (s_left),
    .snap_top    (s_top),
    .snap_width  (s_width),
    .snap_height (s_height),
    .snap_count  (s_count)
  );

  bbs_queue #(.W(SNAP_W)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    ({s_left, s_top, s_width, s_height, s_count}),
    .pop    (q_pop),
    .dout   (q_dout),
    .status (q_status)
  );

  assign {d_left, d_top, d_width, d_height, d_count} = q_dout;

  // back: multi-cycle scoring per particle
  bbs_back #(.C(C)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .q_left       (d_left),
    .q_top        (d_top),
    .q_width      (d_width),
    .q_height     (d_height),
    .q_count      (d_count),
    .q_pop        (q_pop),
    .vert_target  (vert_target),
    .horz_target  (horz_target),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .box_left     (box_left),
    .box_top      (box_top),
    .box_width    (box_width),
    .box_height   (box_height),
    .pixel_total  (pixel_total),
    .rect_score   (rect_score),
    .aspect_score (aspect_score),
    .is_vertical  (is_vertical)
  );

  a_rect_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rect_score <= SCORE_FULL)
    else $error("rect_score above full scale");

  a_aspect_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> aspect_score <= SCORE_FULL)
    else $error("aspect_score above full scale");

  a_vert_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_vertical == (box_height > box_width))
    else $error("is_vertical disagrees with box extents");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_status.avail)
    else $error("queue read while empty");

endmodule
